>>> design/ccext_pkg.sv
// Shared types and constants for the cluster centroid and extent block.
// No dependencies; every other design file imports this package.
package ccext_pkg;

   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_BITS_DEF = 32;

   localparam int COORD_W = 32;
   localparam int SUM_BITS = 48;
   localparam int COUNT_W = 17;

   localparam logic [COORD_W-1:0] LOW_INIT = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] HIGH_INIT = {1'b1, {(COORD_W-1){1'b0}}};

   // One finished cluster as handed from the accumulator to the divider side.
   typedef struct packed {
      logic [SUM_BITS-1:0] sum_x;
      logic [SUM_BITS-1:0] sum_y;
      logic [SUM_BITS-1:0] sum_z;
      logic [COORD_W-1:0] low_x;
      logic [COORD_W-1:0] high_x;
      logic [COORD_W-1:0] low_y;
      logic [COORD_W-1:0] high_y;
      logic [COORD_W-1:0] low_z;
      logic [COORD_W-1:0] high_z;
      logic dropped;
   } ccext_rec_type;

endpackage

>>> design/ccext_front.sv
// Point accumulator: running sums, count and per-axis min/max of the open cluster.
// Depends on ccext_pkg; pushes each closed cluster into ccext_queue.
module ccext_front import ccext_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_point_x,
   input  logic [COORD_W-1:0]  req_point_y,
   input  logic [COORD_W-1:0]  req_point_z,
   input  logic                req_last_point,
   output logic                q_push,
   input  logic                q_ready,
   output ccext_rec_type       q_rec,
   output logic [CNT_BITS-1:0] q_count
);

   localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

   logic [SUM_BITS-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic [SUM_BITS-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic signed [COORD_W-1:0] low_x_ff, high_x_ff, low_y_ff, high_y_ff, low_z_ff, high_z_ff;
   logic signed [COORD_W-1:0] low_x_in, high_x_in, low_y_in, high_y_in, low_z_in, high_z_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic dropped_ff, dropped_in;
   logic signed [COORD_W-1:0] cx, cy, cz;
   logic full, take, close;

   assign cx = COORD_W'($signed(req_point_x[CW-1:0]));
   assign cy = COORD_W'($signed(req_point_y[CW-1:0]));
   assign cz = COORD_W'($signed(req_point_z[CW-1:0]));

   // A last point needs queue room; any other point is always taken.
   assign req_ready = q_ready | ~req_last_point;
   assign take = req_valid & req_ready;
   assign close = take & req_last_point;
   assign full = (count_ff == CNT_BITS'(MAX_POINTS));

   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      low_x_in = low_x_ff;
      high_x_in = high_x_ff;
      low_y_in = low_y_ff;
      high_y_in = high_y_ff;
      low_z_in = low_z_ff;
      high_z_in = high_z_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      if (full) begin
         dropped_in = 1'b1;
      end else begin
         sum_x_in = sum_x_ff + SUM_BITS'(cx);
         sum_y_in = sum_y_ff + SUM_BITS'(cy);
         sum_z_in = sum_z_ff + SUM_BITS'(cz);
         if (cx < low_x_ff) low_x_in = cx;
         if (cx > high_x_ff) high_x_in = cx;
         if (cy < low_y_ff) low_y_in = cy;
         if (cy > high_y_ff) high_y_in = cy;
         if (cz < low_z_ff) low_z_in = cz;
         if (cz > high_z_ff) high_z_in = cz;
         count_in = count_ff + 1'b1;
      end
   end

   assign q_push = close;
   assign q_count = count_in;
   assign q_rec = '{sum_x: sum_x_in, sum_y: sum_y_in, sum_z: sum_z_in,
                    low_x: low_x_in, high_x: high_x_in,
                    low_y: low_y_in, high_y: high_y_in,
                    low_z: low_z_in, high_z: high_z_in,
                    dropped: dropped_in};

   always_ff @(posedge clock) begin
      if (reset || close) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         low_x_ff <= LOW_INIT;
         high_x_ff <= HIGH_INIT;
         low_y_ff <= LOW_INIT;
         high_y_ff <= HIGH_INIT;
         low_z_ff <= LOW_INIT;
         high_z_ff <= HIGH_INIT;
         count_ff <= '0;
         dropped_ff <= 1'b0;
      end else if (take) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
         low_x_ff <= low_x_in;
         high_x_ff <= high_x_in;
         low_y_ff <= low_y_in;
         high_y_ff <= high_y_in;
         low_z_ff <= low_z_in;
         high_z_ff <= high_z_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   a_clear_after_close: assert property (@(posedge clock) disable iff (reset)
      close |=> (count_ff == '0) && !dropped_ff)
      else $error("cluster state not cleared after last point");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count beyond limit");

endmodule

>>> design/ccext_queue.sv
// Two-entry queue of closed clusters between accumulator and divider.
// Depends on ccext_pkg only through the import convention.
module ccext_queue import ccext_pkg::*; #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data
);

   logic [DATA_BITS-1:0] mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 2'd1;
      if (pop && !push) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> push_ready)
      else $error("push into full cluster queue");

endmodule

>>> design/ccext_back.sv
// Result engine: per-axis restoring dividers for the means, spans, output register.
// Depends on ccext_pkg; pops closed clusters from ccext_queue.
module ccext_back import ccext_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  ccext_rec_type       q_rec,
   input  logic [CNT_BITS-1:0] q_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COORD_W-1:0]  rsp_mean_x,
   output logic [COORD_W-1:0]  rsp_mean_y,
   output logic [COORD_W-1:0]  rsp_mean_z,
   output logic [COORD_W-1:0]  rsp_extent_width,
   output logic [COORD_W-1:0]  rsp_extent_height,
   output logic [COUNT_W-1:0]  rsp_point_count,
   output logic                rsp_overflow
);

   localparam int STEP_BITS = $clog2(SUM_BITS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_DONE = 3'b100
   } ccext_state_type;

   ccext_state_type state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff;
   logic [SUM_BITS-1:0] dq_ff [3];
   logic [SUM_BITS-1:0] dq_in [3];
   logic [CNT_BITS-1:0] rem_ff [3];
   logic [CNT_BITS-1:0] rem_in [3];
   logic [SUM_BITS-1:0] mag [3];
   logic [SUM_BITS-1:0] sums [3];
   logic [CNT_BITS:0] trial [3];
   logic [CNT_BITS:0] diff [3];
   logic [COORD_W-1:0] mean [3];
   logic [2:0] neg_ff;
   logic [CNT_BITS-1:0] div_ff;
   logic [COORD_W-1:0] span_x_ff, span_y_ff, span_z_ff;
   logic dropped_ff;
   logic rsp_valid_ff;
   logic [COORD_W-1:0] mean_x_ff, mean_y_ff, mean_z_ff, width_ff, height_ff;
   logic [COUNT_W-1:0] count_ff;
   logic overflow_ff;
   logic load_out;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign sums[0] = q_rec.sum_x;
   assign sums[1] = q_rec.sum_y;
   assign sums[2] = q_rec.sum_z;

   // Divide magnitudes, one quotient bit per cycle on every axis.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         mag[a] = sums[a][SUM_BITS-1] ? (~sums[a] + 1'b1) : sums[a];
         trial[a] = {rem_ff[a], dq_ff[a][SUM_BITS-1]};
         diff[a] = trial[a] - {1'b0, div_ff};
         if (!diff[a][CNT_BITS]) begin
            rem_in[a] = diff[a][CNT_BITS-1:0];
            dq_in[a] = {dq_ff[a][SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in[a] = trial[a][CNT_BITS-1:0];
            dq_in[a] = {dq_ff[a][SUM_BITS-2:0], 1'b0};
         end
         // Restore the sign; only the low word of the quotient is kept.
         mean[a] = neg_ff[a] ? (~dq_ff[a][COORD_W-1:0] + 1'b1) : dq_ff[a][COORD_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (q_valid) state_in = S_DIV;
         S_DIV: if (step_ff == STEP_BITS'(SUM_BITS - 1)) state_in = S_DONE;
         S_DONE: if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         step_ff <= '0;
         div_ff <= q_count;
         dropped_ff <= q_rec.dropped;
         span_x_ff <= q_rec.high_x - q_rec.low_x;
         span_y_ff <= q_rec.high_y - q_rec.low_y;
         span_z_ff <= q_rec.high_z - q_rec.low_z;
         for (int a = 0; a < 3; a++) begin
            dq_ff[a] <= mag[a];
            rem_ff[a] <= '0;
            neg_ff[a] <= sums[a][SUM_BITS-1];
         end
      end else if (state_ff == S_DIV) begin
         step_ff <= step_ff + 1'b1;
         for (int a = 0; a < 3; a++) begin
            dq_ff[a] <= dq_in[a];
            rem_ff[a] <= rem_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         mean_x_ff <= mean[0];
         mean_y_ff <= mean[1];
         mean_z_ff <= mean[2];
         width_ff <= (span_x_ff > span_y_ff) ? span_x_ff : span_y_ff;
         height_ff <= span_z_ff;
         count_ff <= COUNT_W'(div_ff);
         overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean_x = mean_x_ff;
   assign rsp_mean_y = mean_y_ff;
   assign rsp_mean_z = mean_z_ff;
   assign rsp_extent_width = width_ff;
   assign rsp_extent_height = height_ff;
   assign rsp_point_count = count_ff;
   assign rsp_overflow = overflow_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("divide with zero point count");

   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> ($past(state_ff) == S_DIV || $past(state_ff) == S_DONE))
      else $error("result finalize without divide");

   a_no_drop_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result lost");

endmodule

>>> design/cluster_centroid_extent.sv
// Cluster centroid and bounding-box extent: points in at one per cycle.
// Result path from an accepted last point: queue pop, 48-step divide, finalize.
// Throughput: one point per cycle but for the stall below; the divider finishes one cluster before it pops the next.
// A two-cluster queue absorbs bursts; a last point stalls only while that queue is full.
// Reset (synchronous, active high) clears the accumulators, queue and result valid flag; result data is not reset.
module cluster_centroid_extent import ccext_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [COORD_W-1:0] req_point_z,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_mean_x,
   output logic [COORD_W-1:0] rsp_mean_y,
   output logic [COORD_W-1:0] rsp_mean_z,
   output logic [COORD_W-1:0] rsp_extent_width,
   output logic [COORD_W-1:0] rsp_extent_height,
   output logic [COUNT_W-1:0] rsp_point_count,
   output logic               rsp_overflow
);

   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
   localparam int REC_BITS = $bits(ccext_rec_type);
   localparam int DATA_BITS = REC_BITS + CNT_BITS;

   logic q_push, q_ready, q_pop, q_valid;
   ccext_rec_type push_rec, pop_rec;
   logic [CNT_BITS-1:0] push_count, pop_count;
   logic [DATA_BITS-1:0] pop_data;

   ccext_front #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_point_x,
      .req_point_y,
      .req_point_z,
      .req_last_point,
      .q_push,
      .q_ready,
      .q_rec(push_rec),
      .q_count(push_count)
   );

   ccext_queue #(
      .DATA_BITS(DATA_BITS)
   ) u_queue (
      .clock,
      .reset,
      .push(q_push),
      .push_ready(q_ready),
      .push_data({push_count, push_rec}),
      .pop(q_pop),
      .pop_valid(q_valid),
      .pop_data
   );

   assign pop_rec = ccext_rec_type'(pop_data[REC_BITS-1:0]);
   assign pop_count = pop_data[DATA_BITS-1:REC_BITS];

   ccext_back #(
      .MAX_POINTS(MAX_POINTS)
   ) u_back (
      .clock,
      .reset,
      .q_valid,
      .q_pop,
      .q_rec(pop_rec),
      .q_count(pop_count),
      .rsp_valid,
      .rsp_ready,
      .rsp_mean_x,
      .rsp_mean_y,
      .rsp_mean_z,
      .rsp_extent_width,
      .rsp_extent_height,
      .rsp_point_count,
      .rsp_overflow
   );

endmodule

>>> bench/centroid_check.sv
// Checker for cluster_centroid_extent: follows accepted points, predicts the mean,
// extent, count and overflow of each cluster, and compares every accepted result.
// Depends on ccext_pkg for the port widths and the min/max start values.
module centroid_check import ccext_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [COORD_W-1:0] req_point_z,
   input  logic               req_last_point,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [COORD_W-1:0] rsp_mean_x,
   input  logic [COORD_W-1:0] rsp_mean_y,
   input  logic [COORD_W-1:0] rsp_mean_z,
   input  logic [COORD_W-1:0] rsp_extent_width,
   input  logic [COORD_W-1:0] rsp_extent_height,
   input  logic [COUNT_W-1:0] rsp_point_count,
   input  logic               rsp_overflow,
   output int                 fail_count,
   output int                 pending,
   output int                 points_taken,
   output int                 clusters_done
);

   typedef struct {
      logic [COORD_W-1:0] mean_x;
      logic [COORD_W-1:0] mean_y;
      logic [COORD_W-1:0] mean_z;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } cluster_summary_type;

   cluster_summary_type summary_q[$];

   logic signed [SUM_BITS-1:0] sum_x, sum_y, sum_z;
   logic signed [COORD_W-1:0]  low_x, high_x, low_y, high_y, low_z, high_z;
   int unsigned                point_total;
   bit                         dropped;

   task automatic restart_cluster();
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      low_x = LOW_INIT;
      low_y = LOW_INIT;
      low_z = LOW_INIT;
      high_x = HIGH_INIT;
      high_y = HIGH_INIT;
      high_z = HIGH_INIT;
      point_total = 0;
      dropped = 1'b0;
   endtask

   // Truncates toward zero, as SystemVerilog integer division does.
   function automatic logic [COORD_W-1:0] axis_mean(input logic signed [SUM_BITS-1:0] total,
                                                    input int unsigned n);
      longint quot;
      quot = longint'(total) / longint'(n);
      return quot[COORD_W-1:0];
   endfunction

   task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                                input logic [COORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cluster_summary_type       summary;
      logic signed [COORD_W-1:0] px, py, pz;
      logic [COORD_W-1:0]        span_x, span_y;
      if (reset) begin
         restart_cluster();
         summary_q.delete();
         fail_count = 0;
         points_taken = 0;
         clusters_done = 0;
      end else begin
         if (req_valid && req_ready) begin
            points_taken++;
            px = req_point_x;
            py = req_point_y;
            pz = req_point_z;
            // a full cluster drops the point but still closes on last
            if (point_total >= MAX_POINTS) begin
               dropped = 1'b1;
            end else begin
               sum_x = sum_x + px;
               sum_y = sum_y + py;
               sum_z = sum_z + pz;
               if (px < low_x) low_x = px;
               if (px > high_x) high_x = px;
               if (py < low_y) low_y = py;
               if (py > high_y) high_y = py;
               if (pz < low_z) low_z = pz;
               if (pz > high_z) high_z = pz;
               point_total++;
            end
            if (req_last_point) begin
               span_x = high_x - low_x;
               span_y = high_y - low_y;
               summary.mean_x = axis_mean(sum_x, point_total);
               summary.mean_y = axis_mean(sum_y, point_total);
               summary.mean_z = axis_mean(sum_z, point_total);
               summary.width = (span_x > span_y) ? span_x : span_y;
               summary.height = high_z - low_z;
               summary.count = COUNT_W'(point_total);
               summary.overflow = dropped;
               summary_q.insert(summary_q.size(), summary);
               restart_cluster();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               $display("%0t: result with no cluster closed, mean_x %h count %0d",
                        $time, rsp_mean_x, rsp_point_count);
               fail_count++;
            end else begin
               summary = summary_q.pop_front();
               compare_field("mean_x", summary.mean_x, rsp_mean_x);
               compare_field("mean_y", summary.mean_y, rsp_mean_y);
               compare_field("mean_z", summary.mean_z, rsp_mean_z);
               compare_field("extent_width", summary.width, rsp_extent_width);
               compare_field("extent_height", summary.height, rsp_extent_height);
               compare_field("point_count", COORD_W'(summary.count), COORD_W'(rsp_point_count));
               compare_field("overflow", COORD_W'(summary.overflow), COORD_W'(rsp_overflow));
               clusters_done++;
            end
         end
      end
      pending = summary_q.size();
   end

endmodule

>>> bench/tb.sv
// Top of the cluster_centroid_extent bench: clock, reset, point stimulus and verdict.
// Depends on ccext_pkg, the block itself and centroid_check, which does all result checking.
module tb import ccext_pkg::*; ();

   localparam logic [COORD_W-1:0] COORD_TOP = LOW_INIT;
   localparam logic [COORD_W-1:0] COORD_BOTTOM = HIGH_INIT;
   localparam int STUCK_LIMIT = 2000;
   localparam int PHASE_ITEMS = 106;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [COORD_W-1:0] req_point_x = '0;
   logic [COORD_W-1:0] req_point_y = '0;
   logic [COORD_W-1:0] req_point_z = '0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COORD_W-1:0] rsp_mean_x, rsp_mean_y, rsp_mean_z;
   logic [COORD_W-1:0] rsp_extent_width, rsp_extent_height;
   logic [COUNT_W-1:0] rsp_point_count;
   logic               rsp_overflow;

   int fail_count, pending, points_taken, clusters_done;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stuck_cycles = 0;

   cluster_centroid_extent uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mean_x(rsp_mean_x), .rsp_mean_y(rsp_mean_y), .rsp_mean_z(rsp_mean_z),
      .rsp_extent_width(rsp_extent_width), .rsp_extent_height(rsp_extent_height),
      .rsp_point_count(rsp_point_count), .rsp_overflow(rsp_overflow)
   );

   centroid_check checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mean_x(rsp_mean_x), .rsp_mean_y(rsp_mean_y), .rsp_mean_z(rsp_mean_z),
      .rsp_extent_width(rsp_extent_width), .rsp_extent_height(rsp_extent_height),
      .rsp_point_count(rsp_point_count), .rsp_overflow(rsp_overflow),
      .fail_count(fail_count), .pending(pending),
      .points_taken(points_taken), .clusters_done(clusters_done)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // count cycles in which neither channel completes a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_point_x = x;
      req_point_y = y;
      req_point_z = z;
      req_last_point = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] center);
      case ($urandom_range(9))
         0: return $urandom();
         1: return COORD_TOP;
         2: return COORD_BOTTOM;
         3: return $urandom_range(1) ? '0 : '1;
         default: return center + $urandom_range(4095) - 2048;
      endcase
   endfunction

   initial begin
      int                 phase_items;
      int                 cluster_len;
      logic [COORD_W-1:0] cx, cy, cz;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single points at both ends of the range
      send_point(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1);
      send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1);
      // full-range span, negative half sum truncates to zero
      send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b0);
      send_point(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1);
      send_point('0, '0, '0, 1'b1);
      // negative sums truncate toward zero; y span wins the width
      send_point(-5, 9, -1, 1'b0);
      send_point(2, 0, -1, 1'b0);
      send_point(0, 1, 0, 1'b1);
      // x span wins the width
      send_point(1000, 5, -1, 1'b0);
      send_point(-3000, 5, 1, 1'b1);
      send_point('1, COORD_TOP, 32'h5555_5555, 1'b0);
      send_point('1, COORD_TOP, 32'haaaa_aaaa, 1'b0);
      send_point('1, COORD_TOP, '1, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 84; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 84; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            cluster_len = ($urandom_range(9) == 0) ? $urandom_range(40, 20)
                                                   : $urandom_range(8, 1);
            cx = $urandom();
            cy = $urandom();
            cz = $urandom();
            for (int i = 0; i < cluster_len; i++) begin
               send_point(pick_coord(cx), pick_coord(cy), pick_coord(cz), i == cluster_len - 1);
            end
            phase_items += cluster_len;
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      // allow a full divide for any stray result
      repeat (80) @(posedge clock);

      $display("Covered %0d points in %0d clusters under four sender/receiver idle mixes,",
               points_taken, clusters_done);
      $display("including range extremes and clusters of one to forty points.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/ccext_pkg.sv
design/ccext_front.sv
design/ccext_queue.sv
design/ccext_back.sv
design/cluster_centroid_extent.sv
bench/centroid_check.sv
bench/tb.sv
